// ===== src/sacft_pkg.sv =====
// Package for the set-associative FIFO-replacement tag store: types, constants, helpers.
`default_nettype none

package sacft_pkg;

    // Field widths fixed by the interface
    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int CNT_W      = 32;
    localparam int WAY_OUT_W  = 4;
    localparam int OFF_W      = 5;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    // Register map: index is paddr[2]
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_OFFSET = 1'b0;

    localparam logic [OFF_W-1:0] OFF_RESET = 5'd10;

    // Default geometry
    localparam int SETS_DEF = 16;
    localparam int WAYS_DEF = 4;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SET,
        S_CMP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;
        logic start_set;
        logic rd_en;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic set_done;
    } t_status;

    function automatic bit f_is_pow2(input int n);
        return (n & (n - 1)) == 0;
    endfunction

endpackage

`default_nettype wire

// ===== src/set_assoc_cache_fifo_tags_core.sv =====
// Sequence: accept; for non-power-of-two SETS, the reciprocal set-index unit's quotient
// then remainder registers; row read; then compare and result load, held while stalled.
// Lookups: the next is accepted only once the result is loaded, set by the read-then-write
// of the single tag RAM row; a waiting result holds only the next lookup's write-back.
// Reset: offset 10, counters zero; a sweep over every set then clears each set's fill
// level and oldest pointer, with o_ready low throughout.
`default_nettype none

module set_assoc_cache_fifo_tags_core #(
    parameter int SETS = sacft_pkg::SETS_DEF,
    parameter int WAYS = sacft_pkg::WAYS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // APB configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sacft_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [sacft_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [sacft_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready,
    // Lookup channel
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [sacft_pkg::ADDR_W-1:0]      i_address,
    // Result channel
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic                                   o_hit,
    output logic      [sacft_pkg::WAY_OUT_W-1:0]   o_way,
    output logic      [sacft_pkg::CNT_W-1:0]       o_hit_count,
    output logic      [sacft_pkg::CNT_W-1:0]       o_miss_count
);
    import sacft_pkg::*;

    localparam bit FAST = f_is_pow2(SETS);

    logic [OFF_W-1:0]     r_off;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    t_cmd                 cmd;
    t_status              status;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= OFF_RESET;
        end else if (cfg_wr && (reg_idx == REG_BLOCK_OFFSET)) begin
            r_off <= pwdata[OFF_W-1:0];
        end
    end

    assign prdata = (reg_idx == REG_BLOCK_OFFSET) ? APB_DATA_W'(r_off) : '0;

    sacft_ctrl #(
        .FAST (FAST)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    sacft_dp #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_address    (i_address),
        .i_off        (r_off),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_hit        (o_hit),
        .o_way        (o_way),
        .o_hit_count  (o_hit_count),
        .o_miss_count (o_miss_count)
    );

`ifndef NO_ASSERTIONS
    // One lookup at a time: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("lookup accepted while another is in flight");

    // Reported way always lies inside the set
    a_way_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_way) < WAYS))
        else $error("result way out of range");

    // Clearing sweep holds off lookups after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("lookup accepted before clearing sweep");

    // A new result beat moves exactly one counter by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> ((o_hit_count + o_miss_count) ==
                          ($past(o_hit_count) + $past(o_miss_count) + 1'b1)))
        else $error("counters did not advance by one");
`endif

endmodule

`default_nettype wire

// ===== src/sacft_setidx.sv =====
// Set index unit: block number modulo SETS, a mask or a reciprocal multiply.
`default_nettype none

module sacft_setidx #(
    parameter int SETS  = sacft_pkg::SETS_DEF,
    parameter int SET_W = 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [sacft_pkg::TAG_W-1:0]  i_blk,
    output logic                              o_done,
    output logic      [SET_W-1:0]             o_set
);
    import sacft_pkg::*;

    generate
        if (f_is_pow2(SETS)) begin : g_mask
            // Power-of-two set count: low block bits, combinational
            assign o_set  = SET_W'(i_blk & TAG_W'(SETS - 1));
            assign o_done = 1'b1;
        end else begin : g_rem
            // Exact reciprocal: (blk * MAGIC) >> SHIFT is blk / SETS for any 32-bit blk
            localparam int              LOG_S   = $clog2(SETS);
            localparam int              SHIFT   = TAG_W + LOG_S;
            localparam int              PROD_W  = 2 * TAG_W + 1;
            localparam longint unsigned MAGIC_L =
                ((64'd1 << SHIFT) + 64'(SETS) - 64'd1) / 64'(SETS);
            localparam logic [TAG_W:0]  MAGIC   = (TAG_W + 1)'(MAGIC_L);
            localparam logic [1:0]      STEPS   = 2'd2;

            logic [TAG_W-1:0]  r_blk;
            logic [TAG_W-1:0]  r_quo;
            logic [SET_W-1:0]  r_set;
            logic [1:0]        r_cnt;
            logic [PROD_W-1:0] prod;
            logic [TAG_W-1:0]  quo_x_sets;

            assign prod       = PROD_W'(r_blk) * PROD_W'(MAGIC);
            assign quo_x_sets = r_quo * TAG_W'(SETS);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cnt <= '0;
                end else if (i_start) begin
                    r_cnt <= STEPS;
                end else if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end

            // Quotient register first, then the remainder register
            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_blk <= i_blk;
                end
                if (r_cnt == STEPS) begin
                    r_quo <= TAG_W'(prod >> SHIFT);
                end
                if (r_cnt == 2'd1) begin
                    r_set <= SET_W'(r_blk - quo_x_sets);
                end
            end

            assign o_set  = r_set;
            assign o_done = (r_cnt == '0);
        end
    endgenerate

endmodule

`default_nettype wire

// ===== src/sacft_dp.sv =====
// Datapath: tag RAM rows, tag compare, FIFO fill/replace, counters, result register.
`default_nettype none

module sacft_dp #(
    parameter int SETS = sacft_pkg::SETS_DEF,
    parameter int WAYS = sacft_pkg::WAYS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [sacft_pkg::ADDR_W-1:0]     i_address,
    input  wire logic [sacft_pkg::OFF_W-1:0]      i_off,
    input  wire sacft_pkg::t_cmd                  i_cmd,
    output sacft_pkg::t_status                    o_status,
    output logic                                  o_hit,
    output logic      [sacft_pkg::WAY_OUT_W-1:0]  o_way,
    output logic      [sacft_pkg::CNT_W-1:0]      o_hit_count,
    output logic      [sacft_pkg::CNT_W-1:0]      o_miss_count
);
    import sacft_pkg::*;

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W = $clog2(WAYS + 1);
    localparam int FILL_LSB = WAYS * TAG_W;
    localparam int PTR_LSB  = FILL_LSB + FILL_W;
    localparam int ROW_W    = PTR_LSB + WAY_W;

    // Row layout: {oldest pointer, fill level, tags of all ways}
    logic [ROW_W-1:0] mem [SETS];
    logic [ROW_W-1:0] r_row;
    logic [SET_W-1:0] r_set;
    logic [SET_W-1:0] r_clr;
    logic [TAG_W-1:0] r_blk;

    logic [TAG_W-1:0] blk_in;
    logic [SET_W-1:0] set_idx;
    logic             set_done;

    logic [FILL_W-1:0] fill;
    logic [WAY_W-1:0]  ptr;
    logic              hit;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  miss_way;
    logic [WAY_W-1:0]  way_sel;
    logic [FILL_W-1:0] new_fill;
    logic [WAY_W-1:0]  new_ptr;
    logic [ROW_W-1:0]  new_row;

    logic              wr_en;
    logic [SET_W-1:0]  wr_addr;
    logic [ROW_W-1:0]  wr_data;

    logic                 r_hit;
    logic [WAY_OUT_W-1:0] r_way;
    logic [CNT_W-1:0]     r_hits;
    logic [CNT_W-1:0]     r_misses;

    assign blk_in = i_address >> i_off;

    sacft_setidx #(
        .SETS  (SETS),
        .SET_W (SET_W)
    ) u_setidx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_set),
        .i_blk   (blk_in),
        .o_done  (set_done),
        .o_set   (set_idx)
    );

    // Block number held for the compare
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_set) begin
            r_blk <= blk_in;
        end
    end

    // Clearing sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    assign o_status.clr_last = (r_clr == SET_W'(SETS - 1));
    assign o_status.set_done = set_done;

    // Tag compare over the valid ways; lowest match wins
    always_comb begin
        fill    = r_row[FILL_LSB +: FILL_W];
        ptr     = r_row[PTR_LSB +: WAY_W];
        hit     = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if ((FILL_W'(w) < fill) && (r_row[w*TAG_W +: TAG_W] == r_blk)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    // Fill the next free way, else replace the oldest
    always_comb begin
        new_fill = fill;
        new_ptr  = ptr;
        if (fill < FILL_W'(WAYS)) begin
            miss_way = fill[WAY_W-1:0];
            new_fill = fill + 1'b1;
        end else begin
            miss_way = ptr;
            new_ptr  = (ptr == WAY_W'(WAYS - 1)) ? '0 : ptr + 1'b1;
        end
        way_sel = hit ? hit_way : miss_way;

        new_row = r_row;
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == miss_way) begin
                new_row[w*TAG_W +: TAG_W] = r_blk;
            end
        end
        new_row[FILL_LSB +: FILL_W] = new_fill;
        new_row[PTR_LSB +: WAY_W]   = new_ptr;
    end

    // RAM write port: sweep or miss write-back
    assign wr_en   = i_cmd.clr_step | (i_cmd.out_load & ~hit);
    assign wr_addr = i_cmd.clr_step ? r_clr : r_set;
    assign wr_data = i_cmd.clr_step ? '0 : new_row;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_row <= mem[set_idx];
            r_set <= set_idx;
        end
    end

    // Counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits   <= '0;
            r_misses <= '0;
        end else if (i_cmd.out_load) begin
            if (hit) begin
                r_hits <= r_hits + 1'b1;
            end else begin
                r_misses <= r_misses + 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_hit <= hit;
            r_way <= WAY_OUT_W'(way_sel);
        end
    end

    assign o_hit        = r_hit;
    assign o_way        = r_way;
    assign o_hit_count  = r_hits;
    assign o_miss_count = r_misses;

endmodule

`default_nettype wire

// ===== src/sacft_ctrl.sv =====
// Controller: clearing sweep, set lookup sequencing, output beat handshake.
`default_nettype none

module sacft_ctrl #(
    parameter bit FAST = 1'b1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    output logic                    o_valid,
    input  wire logic               i_ready,
    input  wire sacft_pkg::t_status i_status,
    output sacft_pkg::t_cmd         o_cmd
);
    import sacft_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_ovalid;
    logic   n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid & ~i_ready;
        o_cmd    = '0;
        o_ready  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.start_set = 1'b1;
                    if (FAST) begin
                        o_cmd.rd_en = 1'b1;
                        n_state     = S_CMP;
                    end else begin
                        n_state = S_SET;
                    end
                end
            end
            S_SET: begin
                if (i_status.set_done) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_CMP: begin
                // Write back on a miss and load the result once the output slot is free
                if (!r_ovalid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_valid = r_ovalid;

endmodule

`default_nettype wire
